// ===== hw/rtl/ptwa_pkg.sv =====
`default_nettype none
package ptwa_pkg;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_ACT    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_AGE    = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS,
        S_FIN,
        S_DONE
    } t_state;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [31:0]       TIMEOUT_RESET = 32'd300000;
    localparam logic signed [7:0] NEW_STRENGTH  = -8'sd100;

    // Division by ten of a magnitude up to 1280: multiply by 1639 and drop 14 bits.
    localparam logic [10:0] DIV10_MUL   = 11'd1639;
    localparam int          DIV10_SHIFT = 14;

    typedef struct packed {
        logic [47:0]       mac;
        logic [31:0]       seen;
        logic signed [7:0] raw;
        logic signed [7:0] smooth;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    typedef struct packed {
        logic   keep;
        logic   hit;
        t_entry entry;
    } t_head_res;

endpackage
`default_nettype wire

// ===== hw/rtl/peer_table_with_aging.sv =====
// An accepted item enters the pass state, which streams the entry chain through the head
// unit one entry at a time and then sees the pass end; the finish state builds the result,
// and the done state hands it to the output register once that is free (an output stall
// holds it there). Only then does the idle state take the next item, so items never overlap.
// Reset (synchronous, active low) empties the table, sets the timeout to 300000 ms and drops
// any pending result; entry contents are not cleared and are never read before being written.
`default_nettype none
module peer_table_with_aging #(
    parameter int PEER_CAPACITY = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire [2:0]         i_op,
    input  wire [47:0]        i_mac,
    input  wire signed [7:0]  i_rssi,
    input  wire [31:0]        i_now_ms,
    input  wire [5:0]         i_slot,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [1:0]        o_status,
    output logic [5:0]        o_entry_index,
    output logic [6:0]        o_entry_count,
    output logic [6:0]        o_removed_count,
    output logic [47:0]       o_mac_out,
    output logic [31:0]       o_last_seen_out,
    output logic signed [7:0] o_rssi_out,
    output logic signed [7:0] o_smoothed_out,
    input  wire               i_cfg_we,
    input  wire [31:0]        i_cfg_wdata
);

    // Counter width: holds every value from zero up to the capacity itself.
    localparam int CW = $clog2(PEER_CAPACITY + 1);

    // The table is a chain of cells holding the valid entries packed at positions
    // 0..count-1. Each operation runs one pass: every cycle the entry in cell 0 goes
    // through the head unit while all cells shift down by one, and the head entry,
    // if it is kept, is written back behind the entries kept so far. When the pass ends
    // the kept entries sit again at the bottom of the chain in their old order,
    // so removal and age-out compact the table for free.

    ptwa_pkg::t_state r_state;
    ptwa_pkg::t_state n_state;

    ptwa_pkg::t_op     r_op;
    logic [47:0]       r_mac;
    logic signed [7:0] r_rssi;
    logic [31:0]       r_now_ms;
    logic [5:0]        r_slot;
    logic [31:0]       r_timeout_ms;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_kept;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_removed;
    logic          r_found;
    logic          r_full;
    logic [5:0]    r_hit_idx;
    ptwa_pkg::t_entry r_hit;

    // Finished result, waiting for the output register to free up.
    logic [1:0]        r_res_status;
    logic [5:0]        r_res_index;
    logic [6:0]        r_res_removed;
    logic [47:0]       r_res_mac;
    logic [31:0]       r_res_seen;
    logic signed [7:0] r_res_raw;
    logic signed [7:0] r_res_smooth;

    ptwa_pkg::t_entry    cell_q [PEER_CAPACITY];
    ptwa_pkg::t_cell_ctrl cell_ctrl [PEER_CAPACITY];
    ptwa_pkg::t_head_res head_res;
    ptwa_pkg::t_entry    load_data;
    ptwa_pkg::t_entry    new_entry;
    logic [CW-1:0]       load_ptr;
    logic                load_en;
    logic                shift_en;
    logic                accept;
    logic                out_free;
    logic                op_known;

    // Finish-cycle result.
    logic [1:0]        fin_status;
    logic [5:0]        fin_index;
    logic [6:0]        fin_removed;
    logic [47:0]       fin_mac;
    logic [31:0]       fin_seen;
    logic signed [7:0] fin_raw;
    logic signed [7:0] fin_smooth;
    logic              fin_append;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        case (i_op)
            ptwa_pkg::OP_ADD, ptwa_pkg::OP_ACT, ptwa_pkg::OP_REMOVE,
            ptwa_pkg::OP_AGE, ptwa_pkg::OP_READ: op_known = 1'b1;
            default:                             op_known = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------ cells
    genvar gi;
    generate
        for (gi = 0; gi < PEER_CAPACITY; gi++) begin : g_cell
            ptwa_pkg::t_entry next_entry;
            if (gi == PEER_CAPACITY - 1) begin : g_top
                assign next_entry = cell_q[gi];
            end else begin : g_mid
                assign next_entry = cell_q[gi + 1];
            end
            assign cell_ctrl[gi].shift = shift_en;
            assign cell_ctrl[gi].load  = load_en && (load_ptr == CW'(gi));
            ptwa_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (cell_ctrl[gi]),
                .i_next      (next_entry),
                .i_load_data (load_data),
                .o_entry     (cell_q[gi])
            );
        end
    endgenerate

    ptwa_head u_head (
        .i_head       (cell_q[0]),
        .i_op         (r_op),
        .i_mac        (r_mac),
        .i_rssi       (r_rssi),
        .i_now_ms     (r_now_ms),
        .i_timeout_ms (r_timeout_ms),
        .i_found      (r_found),
        .i_pos        (6'(r_idx)),
        .i_slot       (r_slot),
        .o_res        (head_res)
    );

    // ---------------------------------------------------------- state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptwa_pkg::S_IDLE: if (i_in_valid) n_state = ptwa_pkg::S_PASS;
            ptwa_pkg::S_PASS: if (r_rem == '0) n_state = ptwa_pkg::S_FIN;
            ptwa_pkg::S_FIN:  n_state = ptwa_pkg::S_DONE;
            ptwa_pkg::S_DONE: if (out_free) n_state = ptwa_pkg::S_IDLE;
            default:          n_state = ptwa_pkg::S_IDLE;
        endcase
    end

    assign new_entry.mac    = r_mac;
    assign new_entry.seen   = r_now_ms;
    assign new_entry.raw    = ptwa_pkg::NEW_STRENGTH;
    assign new_entry.smooth = ptwa_pkg::NEW_STRENGTH;

    // Chain control: shift during the pass, write back kept entries, append new peers.
    always_comb begin
        o_in_stall = 1'b1;
        shift_en   = 1'b0;
        load_en    = 1'b0;
        load_ptr   = r_rem + r_kept - CW'(1);
        load_data  = head_res.entry;
        unique case (r_state)
            ptwa_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            ptwa_pkg::S_PASS: begin
                shift_en = (r_rem != '0);
                load_en  = (r_rem != '0) && head_res.keep;
            end
            ptwa_pkg::S_FIN: begin
                load_en   = fin_append;
                load_ptr  = r_count;
                load_data = new_entry;
            end
            ptwa_pkg::S_DONE: begin
                o_in_stall = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Result assembly once the pass is complete.
    always_comb begin
        fin_status  = ptwa_pkg::ST_OK;
        fin_index   = '0;
        fin_removed = '0;
        fin_mac     = '0;
        fin_seen    = '0;
        fin_raw     = '0;
        fin_smooth  = '0;
        fin_append  = 1'b0;
        unique case (r_op)
            ptwa_pkg::OP_ADD: begin
                if (r_full) begin
                    fin_status = ptwa_pkg::ST_FULL;
                end else if (r_found) begin
                    fin_index  = r_hit_idx;
                    fin_seen   = r_hit.seen;
                    fin_raw    = r_hit.raw;
                    fin_smooth = r_hit.smooth;
                end else begin
                    fin_append = 1'b1;
                    fin_index  = 6'(r_count);
                    fin_seen   = r_now_ms;
                    fin_raw    = ptwa_pkg::NEW_STRENGTH;
                    fin_smooth = ptwa_pkg::NEW_STRENGTH;
                end
            end
            ptwa_pkg::OP_ACT: begin
                if (r_found) begin
                    fin_index  = r_hit_idx;
                    fin_seen   = r_hit.seen;
                    fin_raw    = r_hit.raw;
                    fin_smooth = r_hit.smooth;
                end else begin
                    fin_status = ptwa_pkg::ST_NOT_FOUND;
                end
            end
            ptwa_pkg::OP_REMOVE: begin
                if (r_found) begin
                    fin_index   = r_hit_idx;
                    fin_removed = 7'd1;
                end else begin
                    fin_status = ptwa_pkg::ST_NOT_FOUND;
                end
            end
            ptwa_pkg::OP_AGE: begin
                fin_removed = 7'(r_removed);
            end
            ptwa_pkg::OP_READ: begin
                if (r_found) begin
                    fin_index  = r_hit_idx;
                    fin_mac    = r_hit.mac;
                    fin_seen   = r_hit.seen;
                    fin_raw    = r_hit.raw;
                    fin_smooth = r_hit.smooth;
                end else begin
                    fin_status = ptwa_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                fin_status = ptwa_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptwa_pkg::S_IDLE;
            r_count      <= '0;
            r_timeout_ms <= ptwa_pkg::TIMEOUT_RESET;
            o_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_timeout_ms <= i_cfg_wdata;
            end
            if (r_state == ptwa_pkg::S_FIN) begin
                r_count <= r_count - r_removed + CW'(fin_append);
            end
            if (r_state == ptwa_pkg::S_DONE && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Operation context and pass bookkeeping.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= ptwa_pkg::t_op'(i_op);
            r_mac     <= i_mac;
            r_rssi    <= i_rssi;
            r_now_ms  <= i_now_ms;
            r_slot    <= i_slot;
            r_full    <= (r_count >= CW'(PEER_CAPACITY));
            r_kept    <= '0;
            r_idx     <= '0;
            r_removed <= '0;
            r_found   <= 1'b0;
            r_hit_idx <= '0;
            // A full add and an unknown code need no pass over the table.
            if (!op_known || (i_op == ptwa_pkg::OP_ADD && r_count >= CW'(PEER_CAPACITY))) begin
                r_rem <= '0;
            end else begin
                r_rem <= r_count;
            end
        end else if (shift_en) begin
            r_rem <= r_rem - CW'(1);
            r_idx <= r_idx + CW'(1);
            if (head_res.keep) begin
                r_kept <= r_kept + CW'(1);
            end else begin
                r_removed <= r_removed + CW'(1);
            end
            if (head_res.hit) begin
                r_found   <= 1'b1;
                r_hit_idx <= 6'(r_idx);
                r_hit     <= head_res.entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ptwa_pkg::S_FIN) begin
            r_res_status  <= fin_status;
            r_res_index   <= fin_index;
            r_res_removed <= fin_removed;
            r_res_mac     <= fin_mac;
            r_res_seen    <= fin_seen;
            r_res_raw     <= fin_raw;
            r_res_smooth  <= fin_smooth;
        end
    end

    // The entry count is final by the hand-off cycle, so it is sampled there.
    always_ff @(posedge i_clk) begin
        if (r_state == ptwa_pkg::S_DONE && out_free) begin
            o_status        <= r_res_status;
            o_entry_index   <= r_res_index;
            o_entry_count   <= 7'(r_count);
            o_removed_count <= r_res_removed;
            o_mac_out       <= r_res_mac;
            o_last_seen_out <= r_res_seen;
            o_rssi_out      <= r_res_raw;
            o_smoothed_out  <= r_res_smooth;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ptwa_cell.sv =====
`default_nettype none
module ptwa_cell (
    input  wire                 i_clk,
    input  ptwa_pkg::t_cell_ctrl i_ctrl,
    input  ptwa_pkg::t_entry    i_next,
    input  ptwa_pkg::t_entry    i_load_data,
    output ptwa_pkg::t_entry    o_entry
);

    ptwa_pkg::t_entry r_entry;

    // A load takes priority over the shift from the upper neighbor.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_entry <= i_load_data;
        end else if (i_ctrl.shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

// ===== hw/rtl/ptwa_head.sv =====
`default_nettype none
module ptwa_head (
    input  ptwa_pkg::t_entry   i_head,
    input  ptwa_pkg::t_op      i_op,
    input  wire [47:0]         i_mac,
    input  wire signed [7:0]   i_rssi,
    input  wire [31:0]         i_now_ms,
    input  wire [31:0]         i_timeout_ms,
    input  wire                i_found,
    input  wire [5:0]          i_pos,
    input  wire [5:0]          i_slot,
    output ptwa_pkg::t_head_res o_res
);

    logic        match;
    logic [31:0] age;
    logic [11:0] s12;
    logic [11:0] r12;
    logic [11:0] sum;
    logic [11:0] mag;
    logic [21:0] prod;
    logic [7:0]  quo;
    logic [7:0]  smooth_new;

    assign match = (i_head.mac == i_mac) && !i_found;
    assign age   = i_now_ms - i_head.seen;

    // Smoothing: (old*7 + new*3)/10, truncated toward zero, in sign-magnitude form; an old zero takes the new value.
    always_comb begin
        s12  = {{4{i_head.smooth[7]}}, i_head.smooth};
        r12  = {{4{i_rssi[7]}}, i_rssi};
        sum  = (s12 << 3) - s12 + (r12 << 1) + r12;
        mag  = sum[11] ? (12'd0 - sum) : sum;
        prod = 22'(mag[10:0]) * 22'(ptwa_pkg::DIV10_MUL);
        quo  = prod[ptwa_pkg::DIV10_SHIFT +: 8];
        if (i_head.smooth == 8'sd0) begin
            smooth_new = i_rssi;
        end else begin
            smooth_new = sum[11] ? (8'd0 - quo) : quo;
        end
    end

    always_comb begin
        o_res.keep  = 1'b1;
        o_res.hit   = 1'b0;
        o_res.entry = i_head;
        unique case (i_op)
            ptwa_pkg::OP_ADD: begin
                if (match) begin
                    o_res.hit        = 1'b1;
                    o_res.entry.seen = i_now_ms;
                end
            end
            ptwa_pkg::OP_ACT: begin
                if (match) begin
                    o_res.hit          = 1'b1;
                    o_res.entry.seen   = i_now_ms;
                    o_res.entry.raw    = i_rssi;
                    o_res.entry.smooth = smooth_new;
                end
            end
            ptwa_pkg::OP_REMOVE: begin
                if (match) begin
                    o_res.hit  = 1'b1;
                    o_res.keep = 1'b0;
                end
            end
            ptwa_pkg::OP_AGE: begin
                o_res.keep = !(age > i_timeout_ms);
            end
            ptwa_pkg::OP_READ: begin
                o_res.hit = (i_pos == i_slot) && !i_found;
            end
            default: begin
                o_res.keep = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire
